// ===== rtl/imu_serial_frame_decoder_assert.svh =====
// Assertion macros used by the decoder's frame tracker.
`ifndef IMU_SERIAL_FRAME_DECODER_ASSERT_SVH
`define IMU_SERIAL_FRAME_DECODER_ASSERT_SVH

// Plain implication property, clocked on clk, off during reset.
`define ISFD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication property.
`define ISFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/isfd_pkg.sv =====
// Shared types, codes and constants of the IMU serial frame decoder.
`timescale 1ns / 1ps
`default_nettype none

package isfd_pkg;

    localparam int FRAME_LEN  = 11;
    localparam int BYTE_W     = 8;
    localparam int RAW_W      = 16;
    localparam int VALUE_W    = 21;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DATA_STORE = 5;

    localparam logic [BYTE_W-1:0] HDR_BYTE        = 8'h55;
    localparam logic [BYTE_W-1:0] TYPE_ACCEL_BYTE = 8'h51;
    localparam logic [BYTE_W-1:0] TYPE_ANGLE_BYTE = 8'h53;

    localparam logic [3:0] POS_HUNT       = 4'd0;
    localparam logic [3:0] POS_TYPE       = 4'd1;
    localparam logic [3:0] POS_FIRST_DATA = 4'd2;
    localparam logic [3:0] POS_LAST_DATA  = 4'd7;
    localparam logic [3:0] POS_FIRST_SKIP = 4'd8;

    localparam logic signed [21:0] ANGLE_BIAS = 22'sd23040;

    typedef enum logic [1:0] {
        KIND_ACCEL = 2'd0,
        KIND_GYRO  = 2'd1,
        KIND_ANGLE = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_TYPE,
        PH_DATA,
        PH_SKIP
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GYRO_OFFSET_X = 2'd0,
        CFG_GYRO_OFFSET_Y = 2'd1,
        CFG_GYRO_OFFSET_Z = 2'd2
    } cfg_index_t;

    typedef struct packed {
        kind_t                   kind;
        logic signed [RAW_W-1:0] raw_x;
        logic signed [RAW_W-1:0] raw_y;
        logic signed [RAW_W-1:0] raw_z;
    } raw_item_t;

    typedef struct packed {
        logic signed [CFG_DATA_W-1:0] x;
        logic signed [CFG_DATA_W-1:0] y;
        logic signed [CFG_DATA_W-1:0] z;
    } gyro_offset_t;

endpackage

`default_nettype wire

// ===== rtl/isfd_if.sv =====
// Valid/ready channel interfaces: byte input, result output, config write.
`timescale 1ns / 1ps
`default_nettype none

interface isfd_byte_if import isfd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface isfd_result_if import isfd_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [1:0]                kind;
    logic signed [VALUE_W-1:0] value_x;
    logic signed [VALUE_W-1:0] value_y;
    logic signed [VALUE_W-1:0] value_z;

    modport source (output valid, output kind, output value_x, output value_y,
                    output value_z, input ready);
    modport sink   (input valid, input kind, input value_x, input value_y,
                    input value_z, output ready);
endinterface

interface isfd_cfg_if import isfd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/isfd_frame_tracker.sv =====
// Frame sync state machine and raw sample register.
`timescale 1ns / 1ps
`default_nettype none

module isfd_frame_tracker
    import isfd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    isfd_byte_if.sink       bytes,
    output logic            raw_valid,
    output raw_item_t       raw_item,
    input  wire logic       raw_ready
);

    `include "imu_serial_frame_decoder_assert.svh"

    phase_t              state_reg, state_next;
    logic [3:0]          pos_reg, pos_next;
    kind_t               type_reg, type_next;
    logic                raw_valid_reg, raw_valid_next;
    raw_item_t           raw_reg, raw_next;
    logic [BYTE_W-1:0]   data_reg [DATA_STORE];

    logic                accept;
    logic                data_we;
    logic                raw_fire;
    logic [2:0]          data_idx;
    logic                type_ok;
    logic [4:0]          pos_inc;

    assign bytes.ready = !raw_valid_reg || raw_ready;
    assign accept      = bytes.valid && bytes.ready;
    assign type_ok     = (bytes.rx_byte >= TYPE_ACCEL_BYTE)
                      && (bytes.rx_byte <= TYPE_ANGLE_BYTE);
    assign pos_inc     = {1'b0, pos_reg} + 5'd1;
    assign data_idx    = 3'(pos_reg - POS_FIRST_DATA);

    // next state
    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        type_next  = type_reg;
        if (accept)
        begin
            unique case (state_reg)
                PH_HUNT:
                begin
                    if (bytes.rx_byte == HDR_BYTE)
                    begin
                        state_next = PH_TYPE;
                        pos_next   = POS_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    priority if (type_ok)
                    begin
                        state_next = PH_DATA;
                        pos_next   = POS_FIRST_DATA;
                        type_next  = kind_t'(2'(bytes.rx_byte - TYPE_ACCEL_BYTE));
                    end
                    else if (bytes.rx_byte != HDR_BYTE)
                    begin
                        state_next = PH_HUNT;
                        pos_next   = POS_HUNT;
                    end
                    else
                    begin
                        // another header: the next byte is the type byte again
                        state_next = PH_TYPE;
                        pos_next   = POS_TYPE;
                    end
                end
                PH_DATA:
                begin
                    if (pos_reg == POS_LAST_DATA)
                    begin
                        if (FRAME_LEN > 8)
                        begin
                            state_next = PH_SKIP;
                            pos_next   = POS_FIRST_SKIP;
                        end
                        else
                        begin
                            state_next = PH_HUNT;
                            pos_next   = POS_HUNT;
                        end
                    end
                    else
                    begin
                        pos_next = pos_inc[3:0];
                    end
                end
                PH_SKIP:
                begin
                    if (pos_inc >= 5'(FRAME_LEN))
                    begin
                        state_next = PH_HUNT;
                        pos_next   = POS_HUNT;
                    end
                    else
                    begin
                        pos_next = pos_inc[3:0];
                    end
                end
                default:
                begin
                    state_next = PH_HUNT;
                    pos_next   = POS_HUNT;
                end
            endcase
        end
    end

    // outputs
    always_comb
    begin
        data_we  = accept && (state_reg == PH_DATA) && (pos_reg != POS_LAST_DATA);
        raw_fire = accept && (state_reg == PH_DATA) && (pos_reg == POS_LAST_DATA);
    end

    // raw sample stage; last data byte comes straight from the input
    always_comb
    begin
        raw_next       = raw_reg;
        raw_valid_next = raw_valid_reg;
        if (raw_fire)
        begin
            raw_next.kind  = type_reg;
            raw_next.raw_x = {data_reg[1], data_reg[0]};
            raw_next.raw_y = {data_reg[3], data_reg[2]};
            raw_next.raw_z = {bytes.rx_byte, data_reg[4]};
            raw_valid_next = 1'b1;
        end
        else if (raw_ready)
        begin
            raw_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= PH_HUNT;
            pos_reg       <= POS_HUNT;
            type_reg      <= KIND_ACCEL;
            raw_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            type_reg      <= type_next;
            raw_valid_reg <= raw_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg <= raw_next;
        if (data_we)
        begin
            data_reg[data_idx] <= bytes.rx_byte;
        end
    end

    assign raw_valid = raw_valid_reg;
    assign raw_item  = raw_reg;

    `ISFD_ASSERT_IMP(a_hunt_pos, state_reg == PH_HUNT, pos_reg == POS_HUNT,
                     "hunt state with nonzero position")
    `ISFD_ASSERT_IMP(a_data_pos, state_reg == PH_DATA,
                     pos_reg >= POS_FIRST_DATA && pos_reg <= POS_LAST_DATA,
                     "data state position out of range")
    `ISFD_ASSERT_NEXT(a_raw_hold, raw_valid_reg && !raw_ready,
                      raw_valid_reg && $stable(raw_reg),
                      "raw sample lost while stalled")
    `ISFD_ASSERT_NEXT(a_fire_loads, raw_fire, raw_valid_reg,
                      "sixth data byte did not load the raw stage")

endmodule

`default_nettype wire

// ===== rtl/isfd_scaler.sv =====
// Q8 scaling of raw samples into the result register.
`timescale 1ns / 1ps
`default_nettype none

module isfd_scaler
    import isfd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         raw_valid,
    input  raw_item_t         raw_item,
    output logic              raw_ready,
    input  gyro_offset_t      offsets,
    isfd_result_if.source     res
);

    logic                      out_valid_reg, out_valid_next;
    logic [1:0]                kind_reg;
    logic signed [VALUE_W-1:0] x_reg, y_reg, z_reg;
    logic                      take;

    // floor division by powers of two is an arithmetic shift
    function automatic logic signed [VALUE_W-1:0] scale_axis(
        input kind_t                        k,
        input logic signed [RAW_W-1:0]      r,
        input logic signed [CFG_DATA_W-1:0] off
    );
        logic signed [23:0] r_ext;
        logic signed [23:0] neg;
        logic signed [23:0] prod;
        logic signed [21:0] acc;
        r_ext = 24'(r);
        neg   = -r_ext;
        prod  = '0;
        unique case (k)
            KIND_ACCEL: acc = 22'(r_ext >>> 3);
            KIND_GYRO:
            begin
                prod = neg * 24'sd125;
                acc  = 22'(prod >>> 3) - 22'(off);
            end
            KIND_ANGLE:
            begin
                prod = neg * 24'sd45;
                acc  = 22'(prod >>> 5) + ANGLE_BIAS;
            end
            default: acc = '0;
        endcase
        return acc[VALUE_W-1:0];
    endfunction

    assign raw_ready = !out_valid_reg || res.ready;
    assign take      = raw_valid && raw_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg <= raw_item.kind;
            x_reg    <= scale_axis(raw_item.kind, raw_item.raw_x, offsets.x);
            y_reg    <= scale_axis(raw_item.kind, raw_item.raw_y, offsets.y);
            z_reg    <= scale_axis(raw_item.kind, raw_item.raw_z, offsets.z);
        end
    end

    assign res.valid   = out_valid_reg;
    assign res.kind    = kind_reg;
    assign res.value_x = x_reg;
    assign res.value_y = y_reg;
    assign res.value_z = z_reg;

endmodule

`default_nettype wire

// ===== rtl/imu_serial_frame_decoder.sv =====
// Top level of the IMU serial frame decoder.
`timescale 1ns / 1ps
`default_nettype none

// Decodes an IMU serial byte stream, one byte per beat on the bytes channel,
// and sends one Q8 result beat (kind, value_x/y/z) per accel, gyro or angle
// frame on the results channel. The tracker hunts for header 0x55 and a type
// byte of 0x51..0x53, gathers six little-endian data bytes, then skips the
// rest of the FRAME_LEN byte frame; no checksum is checked, and 0x55 is only
// looked for while hunting or in the type slot. Rate: one byte per cycle
// while the byte channel is not stalled. The sixth data byte takes a frame
// into the raw sample register; it is then scaled into the result register.
// The byte channel stalls only when both registers hold beats the result sink
// has not taken. Gyro offsets are written on the cfg channel (index 0..2 for
// X, Y, Z; index 3 is ignored), which is always ready; write them only while
// the block is idle. All offsets reset to zero.
module imu_serial_frame_decoder
    import isfd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    isfd_byte_if.sink     bytes,
    isfd_result_if.source results,
    isfd_cfg_if.sink      cfg
);

    gyro_offset_t offsets_reg;
    logic         raw_valid;
    raw_item_t    raw_item;
    logic         raw_ready;

    // config write port, single beat per write
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offsets_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_GYRO_OFFSET_X: offsets_reg.x <= signed'(cfg.data);
                CFG_GYRO_OFFSET_Y: offsets_reg.y <= signed'(cfg.data);
                CFG_GYRO_OFFSET_Z: offsets_reg.z <= signed'(cfg.data);
                default:           offsets_reg   <= offsets_reg;
            endcase
        end
    end

    // frame sync and raw capture
    isfd_frame_tracker u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .bytes     (bytes),
        .raw_valid (raw_valid),
        .raw_item  (raw_item),
        .raw_ready (raw_ready)
    );

    // scaling and result register
    isfd_scaler u_scaler (
        .clk       (clk),
        .rst_n     (rst_n),
        .raw_valid (raw_valid),
        .raw_item  (raw_item),
        .raw_ready (raw_ready),
        .offsets   (offsets_reg),
        .res       (results)
    );

endmodule

`default_nettype wire

// ===== sim/imu_serial_frame_decoder_tb.sv =====
// Self-checking testbench of the IMU serial frame decoder: directed table, then random frames.
`timescale 1ns / 1ps
`default_nettype none

module imu_serial_frame_decoder_tb;
    import isfd_pkg::*;

    localparam int CLK_PERIOD    = 2;
    localparam int NUM_DATA      = 6;
    localparam int NUM_PHASES    = 6;
    localparam int PHASE_BYTES   = 250;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;

    // scaling: accel r/8, gyro -r*125/8, angle -r*45/32 (floor via >>>)
    localparam int ACCEL_SHIFT = 3;
    localparam int GYRO_MUL    = 125;
    localparam int GYRO_SHIFT  = 3;
    localparam int ANGLE_MUL   = 45;
    localparam int ANGLE_SHIFT = 5;

    // cfg index with no register behind it; writes there are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;

    typedef struct packed {
        kind_t                     kind;
        logic signed [VALUE_W-1:0] x;
        logic signed [VALUE_W-1:0] y;
        logic signed [VALUE_W-1:0] z;
    } frame_result_t;

    typedef struct packed {
        logic [BYTE_W-1:0] rx;
        logic              typed;
        frame_result_t     res;
    } stim_row_t;

    localparam frame_result_t NO_RESULT = '0;

    // Directed bytes. Typed results are the obvious ones: raw extremes with
    // zero gyro offsets, as the directed part runs straight after reset.
    localparam int DIRECTED_LEN = 33;
    localparam stim_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
        // accel frame, raw -32768 / 32767 / 0, skip bytes carry headers
        '{8'h55, 1'b0, NO_RESULT},
        '{8'h51, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},
        '{8'h7F, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, '{KIND_ACCEL, -21'sd4096, 21'sd4095, 21'sd0}},
        '{8'h55, 1'b0, NO_RESULT},
        '{8'hAA, 1'b0, NO_RESULT},
        '{8'h55, 1'b0, NO_RESULT},
        // header followed by a bad type byte
        '{8'h55, 1'b0, NO_RESULT},
        '{8'h07, 1'b0, NO_RESULT},
        // header in the type slot, then a gyro frame, raw -1 / 1 / -32768
        '{8'h55, 1'b0, NO_RESULT},
        '{8'h55, 1'b0, NO_RESULT},
        '{8'h52, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},
        '{8'h01, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h80, 1'b1, '{KIND_GYRO, 21'sd15, -21'sd16, 21'sd512000}},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h55, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},
        // angle frame, raw -32768 / 32767 / 0; its skip bytes open the random part
        '{8'h55, 1'b0, NO_RESULT},
        '{8'h53, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},
        '{8'h7F, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, '{KIND_ANGLE, 21'sd69120, -21'sd23039, 21'sd23040}}
    };

    // idle percentages per phase; the last phase runs flat out
    localparam int GAP_BY_PHASE   [NUM_PHASES] = '{20, 0, 30, 10, 40, 0};
    localparam int STALL_BY_PHASE [NUM_PHASES] = '{25, 0, 30, 15, 40, 0};

    logic clk;
    logic rst_n;

    isfd_byte_if   byte_ch ();
    isfd_result_if res_ch ();
    isfd_cfg_if    cfg_ch ();

    imu_serial_frame_decoder dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (byte_ch),
        .results (res_ch),
        .cfg     (cfg_ch)
    );

    // tracker copy: frame position, frame kind, data bytes, gyro offsets
    logic [3:0]                   trk_pos;
    kind_t                        trk_kind;
    logic [BYTE_W-1:0]            trk_data [NUM_DATA];
    logic signed [CFG_DATA_W-1:0] gyro_off [3];

    frame_result_t pending_frames [$];
    int            fail_count;
    int            cycle_count;
    int            gap_pct;
    int            stall_pct;
    bit            hold_req;

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic signed [VALUE_W-1:0] scale_axis(
        input kind_t                        k,
        input logic signed [RAW_W-1:0]      raw,
        input logic signed [CFG_DATA_W-1:0] off
    );
        int r;
        int v;
        r = raw;
        case (k)
            KIND_ACCEL: v = r >>> ACCEL_SHIFT;
            KIND_GYRO:  v = ((-r * GYRO_MUL) >>> GYRO_SHIFT) - int'(off);
            default:    v = ((-r * ANGLE_MUL) >>> ANGLE_SHIFT) + int'(ANGLE_BIAS);
        endcase
        return v[VALUE_W-1:0];
    endfunction

    // Advances the tracker by one byte; returns 1 when the byte completes a frame.
    function automatic bit track_byte(input logic [BYTE_W-1:0] b, output frame_result_t r);
        bit done;
        done = 1'b0;
        r    = NO_RESULT;
        if (trk_pos == POS_HUNT) begin
            if (b == HDR_BYTE)
                trk_pos = POS_TYPE;
        end else if (trk_pos == POS_TYPE) begin
            if (b >= TYPE_ACCEL_BYTE && b <= TYPE_ANGLE_BYTE) begin
                trk_kind = kind_t'(b - TYPE_ACCEL_BYTE);
                trk_pos  = POS_FIRST_DATA;
            end else if (b == HDR_BYTE)
                trk_pos = POS_TYPE;
            else
                trk_pos = POS_HUNT;
        end else if (trk_pos <= POS_LAST_DATA) begin
            trk_data[trk_pos - POS_FIRST_DATA] = b;
            if (trk_pos != POS_LAST_DATA)
                trk_pos = trk_pos + 4'd1;
            else begin
                r.kind = trk_kind;
                r.x = scale_axis(trk_kind, {trk_data[1], trk_data[0]}, gyro_off[0]);
                r.y = scale_axis(trk_kind, {trk_data[3], trk_data[2]}, gyro_off[1]);
                r.z = scale_axis(trk_kind, {trk_data[5], trk_data[4]}, gyro_off[2]);
                trk_pos = (FRAME_LEN > POS_FIRST_SKIP) ? POS_FIRST_SKIP : POS_HUNT;
                done = 1'b1;
            end
        end else begin
            // skipped tail of the frame, never checked for a header
            if (trk_pos + 1 >= FRAME_LEN)
                trk_pos = POS_HUNT;
            else
                trk_pos = trk_pos + 4'd1;
        end
        return done;
    endfunction

    // One byte beat, after an optional idle burst with valid low.
    task automatic send_byte(
        input logic [BYTE_W-1:0] b,
        input logic              typed,
        input frame_result_t     typed_res
    );
        frame_result_t r;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            @(negedge clk);
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(0, 11)) @(negedge clk);
        end
        @(negedge clk);
        byte_ch.valid   <= 1'b1;
        byte_ch.rx_byte <= b;
        do @(posedge clk); while (!byte_ch.ready);
        if (track_byte(b, r))
            pending_frames.push_back(typed ? typed_res : r);
    endtask

    // Mostly whole frames with random content; some noise and broken headers.
    task automatic send_sequence(inout int count);
        logic [BYTE_W-1:0] seq [$];
        logic [BYTE_W-1:0] b;
        int                pick;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            repeat ($urandom_range(1, 8)) seq.push_back(8'($urandom));
        end else if (pick < 20) begin
            do b = 8'($urandom); while (b >= TYPE_ACCEL_BYTE && b <= TYPE_ANGLE_BYTE);
            seq.push_back(HDR_BYTE);
            seq.push_back(b);
        end else begin
            if (pick < 26)
                repeat ($urandom_range(1, 3)) seq.push_back(HDR_BYTE);
            seq.push_back(HDR_BYTE);
            seq.push_back(TYPE_ACCEL_BYTE + 8'($urandom_range(0, 2)));
            repeat (NUM_DATA) begin
                case ($urandom_range(0, 7))
                    0:       seq.push_back(8'h00);
                    1:       seq.push_back(8'hFF);
                    2:       seq.push_back(8'h80);
                    3:       seq.push_back(8'h7F);
                    default: seq.push_back(8'($urandom));
                endcase
            end
            repeat (FRAME_LEN - POS_FIRST_SKIP)
                seq.push_back(($urandom_range(0, 3) == 0) ? HDR_BYTE : 8'($urandom));
        end
        foreach (seq[i])
            send_byte(seq[i], 1'b0, NO_RESULT);
        count += seq.size();
    endtask

    // Leaves cfg valid high; the caller drops it after its last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        if (idx <= CFG_GYRO_OFFSET_Z)
            gyro_off[idx] = val;
    endtask

    task automatic set_offsets(input logic [CFG_DATA_W-1:0] ox, oy, oz);
        write_reg(CFG_GYRO_OFFSET_X, ox);
        write_reg(CFG_GYRO_OFFSET_Y, oy);
        write_reg(CFG_GYRO_OFFSET_Z, oz);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Stop offering bytes, let every frame come out, then allow for the pipeline.
    task automatic drain();
        @(negedge clk);
        byte_ch.valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] rand_offset(input bit in_range);
        int t;
        t = int'($urandom_range(0, 51200)) - 25600;
        return in_range ? t[CFG_DATA_W-1:0] : CFG_DATA_W'($urandom);
    endfunction

    // Result sink: random stall bursts, and one long hold-off on request.
    initial begin
        bit hold_served;
        hold_served  = 1'b0;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_req && !hold_served) begin
                hold_served = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 11)) @(negedge clk);
            end else
                res_ch.ready <= 1'b1;
        end
    end

    // Result checker: each beat against the oldest predicted frame.
    always @(posedge clk) begin
        frame_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_frames.size() == 0) begin
                $error("result beat with nothing pending: kind %0d x %0d y %0d z %0d",
                       res_ch.kind, res_ch.value_x, res_ch.value_y, res_ch.value_z);
                fail_count++;
            end else begin
                want = pending_frames.pop_front();
                if (res_ch.kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, res_ch.kind);
                    fail_count++;
                end
                if (res_ch.value_x !== want.x) begin
                    $error("value_x: expected %0d, got %0d", want.x, res_ch.value_x);
                    fail_count++;
                end
                if (res_ch.value_y !== want.y) begin
                    $error("value_y: expected %0d, got %0d", want.y, res_ch.value_y);
                    fail_count++;
                end
                if (res_ch.value_z !== want.z) begin
                    $error("value_z: expected %0d, got %0d", want.z, res_ch.value_z);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int sent;
        fail_count      = 0;
        cycle_count     = 0;
        hold_req        = 1'b0;
        gap_pct         = GAP_BY_PHASE[0];
        stall_pct       = STALL_BY_PHASE[0];
        trk_pos         = POS_HUNT;
        trk_kind        = KIND_ACCEL;
        gyro_off        = '{default: '0};
        byte_ch.valid   = 1'b0;
        byte_ch.rx_byte = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = '0;
        cfg_ch.data     = '0;
        rst_n           = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_LEN; i++)
            send_byte(DIRECTED_ROWS[i].rx, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);

        // phase 0 keeps the reset offsets; later phases retune them while idle
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph != 0) begin
                drain();
                case (ph)
                    1: set_offsets(-16'sd25600, 16'sd25600, 16'sd0);
                    2: set_offsets(16'sd25600, -16'sd25600, -16'sd25600);
                    3: set_offsets(16'h8000, 16'h7FFF, 16'hFFFF);
                    4: begin
                        write_reg(CFG_SPARE_INDEX, CFG_DATA_W'($urandom));
                        set_offsets(rand_offset(1'b1), rand_offset(1'b1), rand_offset(1'b1));
                    end
                    default: set_offsets(rand_offset(1'b0), rand_offset(1'b0),
                                         rand_offset(1'b0));
                endcase
            end
            gap_pct   = GAP_BY_PHASE[ph];
            stall_pct = STALL_BY_PHASE[ph];
            // long sink hold-off while bytes keep coming, so the input backs up
            if (ph == 2)
                hold_req = 1'b1;
            sent = 0;
            while (sent < PHASE_BYTES)
                send_sequence(sent);
        end

        drain();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== imu_serial_frame_decoder.f =====
+incdir+rtl
rtl/isfd_pkg.sv
rtl/isfd_if.sv
rtl/isfd_frame_tracker.sv
rtl/isfd_scaler.sv
rtl/imu_serial_frame_decoder.sv
sim/imu_serial_frame_decoder_tb.sv
